FILE: design/jacobi_symbol_unit_top_assert.svh
// Assertion helpers for the checking code of the block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef JACOBI_SYMBOL_UNIT_TOP_ASSERT_SVH
`define JACOBI_SYMBOL_UNIT_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/jsu_pkg.sv
package jsu_pkg;

  localparam int FIELD_BITS = 32;

  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  typedef struct packed {
    logic [FIELD_BITS-1:0] number;
    logic [FIELD_BITS-1:0] modulus;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] symbol;
    logic              bad_modulus;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } status_t;

endpackage

FILE: design/jsu_datapath.sv
module jsu_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  jsu_pkg::in_item_t in_item,
  input  jsu_pkg::cmd_t    cmd,
  output jsu_pkg::status_t status,
  output jsu_pkg::out_item_t result
);
  import jsu_pkg::*;

  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] m;
  logic                 neg;
  logic                 bad;
  logic [WORD_BITS-1:0] a_next;
  logic [WORD_BITS-1:0] m_next;
  logic                 neg_next;
  logic [WORD_BITS:0]   a_minus_m;
  logic [WORD_BITS-1:0] m_minus_a;
  logic [WORD_BITS-1:0] load_a;
  logic [WORD_BITS-1:0] load_m;
  out_item_t            result_next;

  assign load_a    = WORD_BITS'(in_item.number);
  assign load_m    = WORD_BITS'(in_item.modulus);
  assign a_minus_m = {1'b0, a} - {1'b0, m};
  assign m_minus_a = m - a;

  always_comb begin
    a_next   = a;
    m_next   = m;
    neg_next = neg;
    if (!a[0]) begin
      // halve out a factor of two
      a_next = a >> 1;
      if (m[2:0] == 3'd3 || m[2:0] == 3'd5) begin
        neg_next = ~neg;
      end
    end else if (!a_minus_m[WORD_BITS]) begin
      a_next = a_minus_m[WORD_BITS-1:0];
    end else begin
      // swap with reciprocity, then subtract
      a_next = m_minus_a;
      m_next = a;
      if (a[1:0] == 2'd3 && m[1:0] == 2'd3) begin
        neg_next = ~neg;
      end
    end
  end

  always_comb begin
    result_next.bad_modulus = bad;
    if (bad || m != WORD_BITS'(1)) begin
      result_next.symbol = SYM_ZERO;
    end else if (neg) begin
      result_next.symbol = SYM_NEG;
    end else begin
      result_next.symbol = SYM_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bad <= ~load_m[0];
      a   <= load_m[0] ? load_a : '0;
      m   <= load_m;
      neg <= 1'b0;
    end else if (cmd.step) begin
      a   <= a_next;
      m   <= m_next;
      neg <= neg_next;
    end
    if (cmd.capture) begin
      result <= result_next;
    end
  end

  assign status.done = (a == '0);

endmodule

FILE: design/jsu_controller.sv
`include "jacobi_symbol_unit_top_assert.svh"

module jsu_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  jsu_pkg::status_t status,
  output jsu_pkg::cmd_t    cmd
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.done) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.capture = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `JSU_ASSERT_ALWAYS(a_capture_when_done, !cmd.capture || status.done, "capture before done")
  `JSU_ASSERT_ALWAYS(a_capture_slot_free, !cmd.capture || out_free, "capture over held item")
  `JSU_ASSERT_NEXT(a_accept_runs, in_valid && !in_stall, state == ST_RUN, "accept without run")
  `JSU_ASSERT_NEXT(a_capture_shows, cmd.capture, out_valid, "captured item not shown")

endmodule

FILE: design/jacobi_symbol_unit_top.sv
// Channel  Handshake           Payload     Fields
// in       in_valid/in_stall   in_item     number[31:0], modulus[31:0]
// out      out_valid/out_stall out_item    symbol[1:0] signed, bad_modulus
//
// One item at a time: a load, then one binary Jacobi step per cycle
// (halve, subtract, or swap-and-subtract), then a hand-off once the slot frees.
// The number of steps depends on the operands.
// An even modulus loads a zero number and needs no steps.
// Reset (rst, synchronous) clears the controller state and the output valid.
// A stalled result is held in the output register; the next item is accepted
// meanwhile and its finish waits in the run state until the slot frees.
module jacobi_symbol_unit_top #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  jsu_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output jsu_pkg::out_item_t out_item
);
  import jsu_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: accept, iterate until the number reaches zero, hand off
  jsu_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // number/modulus registers, sign, and the output item register
  jsu_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .in_item (in_item),
    .cmd     (cmd),
    .status  (status),
    .result  (out_item)
  );

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  // Score results against a local Jacobi computation, in order of acceptance.
  class jacobi_scoreboard;
    out_item_t pending_symbols[$];
    int errors;
    int n_checked;
    int n_neg;
    int n_zero;
    int n_pos;
    int n_bad;

    // Reciprocity with modulo reduction on the word-sized operands.
    function out_item_t jacobi_of(in_item_t it);
      logic [FIELD_BITS-1:0] a;
      logic [FIELD_BITS-1:0] m;
      logic [FIELD_BITS-1:0] t;
      int sign;
      out_item_t r;
      r.symbol = SYM_ZERO;
      r.bad_modulus = 1'b0;
      // Even modulus, zero included: flag it and give a zero symbol.
      if (!it.modulus[0]) begin
        r.bad_modulus = 1'b1;
        return r;
      end
      sign = 1;
      m = it.modulus;
      a = it.number % m;
      while (a != 0) begin
        while (!a[0]) begin
          a = a >> 1;
          if (m[2:0] == 3'd3 || m[2:0] == 3'd5)
            sign = -sign;
        end
        t = a;
        a = m;
        m = t;
        if (a[1:0] == 2'b11 && m[1:0] == 2'b11)
          sign = -sign;
        a = a % m;
      end
      // Anything but a final modulus of one means a shared factor.
      if (m == 1)
        r.symbol = (sign > 0) ? SYM_POS : SYM_NEG;
      return r;
    endfunction

    function void note_item(in_item_t it);
      pending_symbols.push_back(jacobi_of(it));
    endfunction

    function int pending();
      return pending_symbols.size();
    endfunction

    task report_mismatch(string what, logic [1:0] got, logic [1:0] exp_val);
      if (errors < 20)
        $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, exp_val);
      errors++;
    endtask

    task check_symbol(out_item_t got);
      out_item_t exp_item;
      if (pending_symbols.size() == 0) begin
        report_mismatch("result with no item pending", got.symbol, SYM_ZERO);
        return;
      end
      exp_item = pending_symbols.pop_front();
      n_checked++;
      if (got.symbol != exp_item.symbol)
        report_mismatch("symbol", got.symbol, exp_item.symbol);
      if (got.bad_modulus != exp_item.bad_modulus)
        report_mismatch("bad_modulus", {1'b0, got.bad_modulus},
                        {1'b0, exp_item.bad_modulus});
      if (exp_item.bad_modulus) n_bad++;
      else if (exp_item.symbol == SYM_NEG) n_neg++;
      else if (exp_item.symbol == SYM_POS) n_pos++;
      else n_zero++;
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Idle odds in percent, changed per phase by the stimulus.
  int idle_in_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;

  jacobi_scoreboard sb = new();

  jacobi_symbol_unit_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: check the item taken at this edge, then pick the next stall.
  // Values read here are the ones from before the edge, so no race with the DUT.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_symbol(out_item);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one item, with random idle cycles first, and hold it until taken.
  // Leave valid high on return so back-to-back items need no extra edge.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  task automatic send_pair(input logic [31:0] num, input logic [31:0] modv);
    in_item_t it;
    it.number  = num;
    it.modulus = modv;
    send_item(it);
  endtask

  // Mix of operand shapes: mostly odd moduli with full-width numbers, plus
  // small operands, shared factors, multiples of the modulus and even moduli.
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [31:0] f;
    int          kind;
    kind = $urandom_range(99);
    it.number  = $urandom;
    it.modulus = $urandom | 32'd1;
    if (kind < 15) begin
      it.modulus = $urandom_range(255) | 32'd1;
      it.number  = $urandom_range(1023);
    end else if (kind < 27) begin
      f = $urandom_range(99) | 32'd1;
      it.modulus = f * ($urandom_range(32'h00FF_FFFF) | 32'd1);
      it.number  = f * $urandom_range(32'h01FF_FFFF);
    end else if (kind < 33) begin
      it.number = it.modulus * $urandom_range(7);
    end else if (kind < 43) begin
      it.modulus = ($urandom_range(9) == 0) ? 32'd0 : ($urandom & ~32'd1);
    end else if (kind < 48) begin
      it.modulus = 32'd1;
    end
    return it;
  endfunction

  // Stimulus: reset, directed corners, then four random phases of idle and stall odds.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Even moduli, zero among them.
    send_pair(32'd5, 32'd0);
    send_pair(32'hFFFF_FFFF, 32'd2);
    send_pair(32'd0, 32'hFFFF_FFFE);
    send_pair(32'h8000_0000, 32'h8000_0000);
    // Modulus of one gives +1 for any number.
    send_pair(32'd0, 32'd1);
    send_pair(32'hFFFF_FFFF, 32'd1);
    send_pair(32'd12345, 32'd1);
    // Shared factors, including number equal to or a multiple of the modulus.
    send_pair(32'd0, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'd15, 32'd21);
    send_pair(32'd42, 32'd21);
    // Sign flips from halving and from reciprocity.
    send_pair(32'd2, 32'd3);
    send_pair(32'd2, 32'd7);
    send_pair(32'd3, 32'd7);
    send_pair(32'd7, 32'd3);
    send_pair(32'd1, 32'hFFFF_FFFB);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFB);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h8000_0001);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'h5555_5555, 32'hAAAA_AAAB);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_in_pct = 0;  stall_pct = 0;  end
        1: begin idle_in_pct = 47; stall_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_pct = 47; end
        default: begin idle_in_pct = 11; stall_pct = 11; end
      endcase
      for (int i = 0; i < 400; i++)
        send_item(random_item());
      drain_results();
    end

    // All accepted; give the block time to show any stray result.
    stall_pct = 0;
    repeat (128) @(posedge clk);

    $display("Sent %0d items, checked %0d results (bad modulus, -1, 0, +1: %0d %0d %0d %0d)",
             items_sent, sb.n_checked, sb.n_bad, sb.n_neg, sb.n_zero, sb.n_pos);
    $display("Idling phases: none, sender 47%%, receiver 47%%, both 11%%; %0d mismatches",
             sb.errors);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #80_000_000;
    $display("TIMEOUT with %0d results outstanding", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: jacobi_symbol_unit_top.f
+incdir+design
design/jsu_pkg.sv
design/jsu_datapath.sv
design/jsu_controller.sv
design/jacobi_symbol_unit_top.sv
test/tb.sv
